/* rtl/core/acsd_pkg.sv */
// shared types, constants and helper functions for the alarm clock block
package acsd_pkg;

  localparam int NumDigits = 8;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_KEY    = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  localparam logic [1:0] KEY_DEC   = 2'd0;
  localparam logic [1:0] KEY_INC   = 2'd1;
  localparam logic [1:0] KEY_ALARM = 2'd2;
  localparam logic [1:0] KEY_CLOCK = 2'd3;

  localparam logic [2:0] MODE_RUN       = 3'd0;
  localparam logic [2:0] MODE_SET_CLK_H = 3'd1;
  localparam logic [2:0] MODE_SET_CLK_M = 3'd2;
  localparam logic [2:0] MODE_SET_CLK_S = 3'd3;
  localparam logic [2:0] MODE_ALARM     = 3'd4;
  localparam logic [2:0] MODE_SET_ALM_H = 3'd5;
  localparam logic [2:0] MODE_SET_ALM_M = 3'd6;
  localparam logic [2:0] MODE_SET_ALM_S = 3'd7;

  localparam logic [1:0] WF_SECONDS = 2'd0;
  localparam logic [1:0] WF_MINUTES = 2'd1;
  localparam logic [1:0] WF_HOURS   = 2'd2;

  localparam logic [1:0] REG_BLINK_HALF = 2'd0;
  localparam logic [1:0] REG_FLASH_HALF = 2'd1;
  localparam logic [1:0] REG_DURATION   = 2'd2;

  localparam logic [15:0] BlinkHalfReset = 16'd1000;
  localparam logic [15:0] FlashHalfReset = 16'd200;
  localparam logic [15:0] DurationReset  = 16'd5000;

  localparam logic [5:0] MaxHours = 6'd23;
  localparam logic [5:0] MaxMinSec = 6'd59;

  localparam logic [7:0] SEG_DASH  = 8'hBF;
  localparam logic [7:0] SEG_BLANK = 8'hFF;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] key;
    logic [5:0] sample_hours_bcd;
    logic [6:0] sample_minutes_bcd;
    logic [6:0] sample_seconds_bcd;
  } item_t;

  typedef struct packed {
    logic [2:0] digit_select;
    logic [7:0] segments;
    logic       alarm_led;
    logic       write_valid;
    logic [1:0] write_field;
    logic [6:0] write_bcd;
    logic [2:0] current_mode;
  } result_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] seg;
    unique case (digit)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

  // tens digit of a value below 60
  function automatic logic [3:0] tens_of(input logic [5:0] v);
    logic [3:0] t;
    priority if (v >= 6'd50) t = 4'd5;
    else if (v >= 6'd40) t = 4'd4;
    else if (v >= 6'd30) t = 4'd3;
    else if (v >= 6'd20) t = 4'd2;
    else if (v >= 6'd10) t = 4'd1;
    else t = 4'd0;
    return t;
  endfunction

  function automatic logic [3:0] ones_of(input logic [5:0] v);
    logic [3:0] t;
    logic [5:0] tens10;
    t = tens_of(v);
    tens10 = {t[2:0], 3'b000} - 6'd0 + {1'b0, t, 1'b0};
    return 4'(v - tens10);
  endfunction

  function automatic logic [5:0] step_value(input logic [5:0] v, input logic [5:0] maxv,
                                            input logic up);
    logic [5:0] r;
    if (up) begin
      r = (v >= maxv) ? 6'd0 : v + 6'd1;
    end else begin
      r = (v == 6'd0) ? maxv : v - 6'd1;
    end
    return r;
  endfunction

  function automatic logic [5:0] bcd_decode(input logic [2:0] hi, input logic [3:0] lo,
                                            input logic [5:0] maxv);
    logic [6:0] d;
    d = {hi, 3'b000} + {2'b00, hi, 1'b0} + {3'b000, lo};
    return (d > {1'b0, maxv}) ? maxv : d[5:0];
  endfunction

endpackage

/* rtl/core/alarm_clock_set_and_display_top.sv */
// top level of the alarm clock set and display block
// One transaction per clock cycle is taken while the output is not stalled; an accepted
// transaction passes the input register, then the combinational update of the clock, alarm,
// mode and scan state, whose result is registered in the result register. The input side stalls
// only while a result is held by a stalled output and another transaction waits in the
// input register.
module alarm_clock_set_and_display_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  key_i,
  input  logic [5:0]  sample_hours_bcd_i,
  input  logic [6:0]  sample_minutes_bcd_i,
  input  logic [6:0]  sample_seconds_bcd_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  digit_select_o,
  output logic [7:0]  segments_o,
  output logic        alarm_led_o,
  output logic        write_valid_o,
  output logic [1:0]  write_field_o,
  output logic [6:0]  write_bcd_o,
  output logic [2:0]  current_mode_o
);

  acsd_pkg::item_t   item_in, item_q;
  acsd_pkg::result_t result_d, result_q;
  logic              item_valid;
  logic              advance;

  assign item_in.command            = command_i;
  assign item_in.key                = key_i;
  assign item_in.sample_hours_bcd   = sample_hours_bcd_i;
  assign item_in.sample_minutes_bcd = sample_minutes_bcd_i;
  assign item_in.sample_seconds_bcd = sample_seconds_bcd_i;

  acsd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item_in),
    .advance_i  (advance),
    .valid_o    (item_valid),
    .item_o     (item_q)
  );

  acsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (item_q),
    .result_o    (result_d)
  );

  acsd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_valid),
    .advance_o   (advance),
    .result_i    (result_d),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result_q)
  );

  assign digit_select_o = result_q.digit_select;
  assign segments_o     = result_q.segments;
  assign alarm_led_o    = result_q.alarm_led;
  assign write_valid_o  = result_q.write_valid;
  assign write_field_o  = result_q.write_field;
  assign write_bcd_o    = result_q.write_bcd;
  assign current_mode_o = result_q.current_mode;

endmodule

/* rtl/core/acsd_in_stage.sv */
// input register holding one accepted transaction
module acsd_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  acsd_pkg::item_t     item_i,
  input  logic                advance_i,
  output logic                valid_o,
  output acsd_pkg::item_t     item_o
);

  logic            valid_q, valid_d;
  acsd_pkg::item_t item_q;
  logic            load;

  assign in_stall_o = valid_q & ~advance_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign valid_d    = load | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/core/acsd_core.sv */
// clock, alarm, mode and display state with the per-transaction update
module acsd_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                advance_i,
  input  acsd_pkg::item_t     item_i,
  output acsd_pkg::result_t   result_o
);

  logic [15:0] blink_half_q, flash_half_q, duration_q;
  logic [2:0]  mode_q, mode_d;
  logic [4:0]  clk_h_q, clk_h_d;
  logic [5:0]  clk_m_q, clk_m_d, clk_s_q, clk_s_d;
  logic [4:0]  alm_h_q, alm_h_d;
  logic [5:0]  alm_m_q, alm_m_d, alm_s_q, alm_s_d;
  logic        blink_phase_q, blink_phase_d;
  logic [15:0] blink_count_q, blink_count_d;
  logic [2:0]  scan_q, scan_d;
  logic        alarm_active_q, alarm_active_d;
  logic [16:0] flash_count_q, flash_count_d;
  logic [15:0] duration_count_q, duration_count_d;
  logic        match_before_q, match_before_d;

  logic        wvalid;
  logic [1:0]  wfield;
  logic [5:0]  wval;
  logic [3:0]  wtens;
  logic        up;
  logic        match;
  logic [15:0] blink_inc;
  logic [16:0] flash_inc;
  logic [15:0] dur_inc;
  logic [3:0]  scan_inc;

  logic [5:0]  disp_h, disp_m, disp_s, disp_val;
  logic [1:0]  which;
  logic        is_tens, fixed;
  logic [7:0]  fixed_seg, segs;

  always_comb begin
    mode_d           = mode_q;
    clk_h_d          = clk_h_q;
    clk_m_d          = clk_m_q;
    clk_s_d          = clk_s_q;
    alm_h_d          = alm_h_q;
    alm_m_d          = alm_m_q;
    alm_s_d          = alm_s_q;
    blink_phase_d    = blink_phase_q;
    blink_count_d    = blink_count_q;
    scan_d           = scan_q;
    alarm_active_d   = alarm_active_q;
    flash_count_d    = flash_count_q;
    duration_count_d = duration_count_q;
    match_before_d   = match_before_q;
    wvalid           = 1'b0;
    wfield           = acsd_pkg::WF_SECONDS;
    wval             = 6'd0;
    up               = (item_i.key == acsd_pkg::KEY_INC);
    match            = (clk_h_q == alm_h_q) && (clk_m_q == alm_m_q) && (clk_s_q == alm_s_q);
    blink_inc        = blink_count_q + 16'd1;
    flash_inc        = flash_count_q + 17'd1;
    dur_inc          = duration_count_q + 16'd1;
    scan_inc         = {1'b0, scan_q} + 4'd1;

    unique case (item_i.command)
      acsd_pkg::CMD_TICK: begin
        if (blink_inc >= blink_half_q) begin
          blink_phase_d = ~blink_phase_q;
          blink_count_d = 16'd0;
        end else begin
          blink_count_d = blink_inc;
        end
        if (alarm_active_q) begin
          flash_count_d    = (flash_inc >= {flash_half_q, 1'b0}) ? 17'd0 : flash_inc;
          duration_count_d = dur_inc;
          if (dur_inc >= duration_q) begin
            alarm_active_d   = 1'b0;
            flash_count_d    = 17'd0;
            duration_count_d = 16'd0;
          end
        end
        if (match && !match_before_q) begin
          alarm_active_d   = 1'b1;
          flash_count_d    = 17'd0;
          duration_count_d = 16'd0;
        end
        match_before_d = match;
        scan_d = (scan_inc >= 4'(acsd_pkg::NumDigits)) ? 3'd0 : scan_inc[2:0];
      end
      acsd_pkg::CMD_KEY: begin
        alarm_active_d   = 1'b0;
        flash_count_d    = 17'd0;
        duration_count_d = 16'd0;
        unique case (item_i.key)
          acsd_pkg::KEY_CLOCK: begin
            mode_d = (mode_q < acsd_pkg::MODE_SET_CLK_S) ? mode_q + 3'd1 : acsd_pkg::MODE_RUN;
          end
          acsd_pkg::KEY_ALARM: begin
            mode_d = (mode_q < acsd_pkg::MODE_ALARM || mode_q == acsd_pkg::MODE_SET_ALM_S) ?
                     acsd_pkg::MODE_ALARM : mode_q + 3'd1;
          end
          default: begin
            unique case (mode_q)
              acsd_pkg::MODE_SET_CLK_H: begin
                wval    = acsd_pkg::step_value({1'b0, clk_h_q}, acsd_pkg::MaxHours, up);
                clk_h_d = wval[4:0];
                wvalid  = 1'b1;
                wfield  = acsd_pkg::WF_HOURS;
              end
              acsd_pkg::MODE_SET_CLK_M: begin
                wval    = acsd_pkg::step_value(clk_m_q, acsd_pkg::MaxMinSec, up);
                clk_m_d = wval;
                wvalid  = 1'b1;
                wfield  = acsd_pkg::WF_MINUTES;
              end
              acsd_pkg::MODE_SET_CLK_S: begin
                wval    = acsd_pkg::step_value(clk_s_q, acsd_pkg::MaxMinSec, up);
                clk_s_d = wval;
                wvalid  = 1'b1;
                wfield  = acsd_pkg::WF_SECONDS;
              end
              acsd_pkg::MODE_SET_ALM_H: begin
                alm_h_d = 5'(acsd_pkg::step_value({1'b0, alm_h_q}, acsd_pkg::MaxHours, up));
              end
              acsd_pkg::MODE_SET_ALM_M: begin
                alm_m_d = acsd_pkg::step_value(alm_m_q, acsd_pkg::MaxMinSec, up);
              end
              acsd_pkg::MODE_SET_ALM_S: begin
                alm_s_d = acsd_pkg::step_value(alm_s_q, acsd_pkg::MaxMinSec, up);
              end
              default: begin
              end
            endcase
          end
        endcase
      end
      acsd_pkg::CMD_SAMPLE: begin
        if (mode_q < acsd_pkg::MODE_SET_CLK_H || mode_q > acsd_pkg::MODE_SET_CLK_S) begin
          clk_h_d = 5'(acsd_pkg::bcd_decode({1'b0, item_i.sample_hours_bcd[5:4]},
                                            item_i.sample_hours_bcd[3:0], acsd_pkg::MaxHours));
          clk_m_d = acsd_pkg::bcd_decode(item_i.sample_minutes_bcd[6:4],
                                         item_i.sample_minutes_bcd[3:0], acsd_pkg::MaxMinSec);
          clk_s_d = acsd_pkg::bcd_decode(item_i.sample_seconds_bcd[6:4],
                                         item_i.sample_seconds_bcd[3:0], acsd_pkg::MaxMinSec);
        end
      end
      default: begin
      end
    endcase
  end

  // display digit from the updated state at the current scan position
  always_comb begin
    disp_h    = (mode_d >= acsd_pkg::MODE_ALARM) ? {1'b0, alm_h_d} : {1'b0, clk_h_d};
    disp_m    = (mode_d >= acsd_pkg::MODE_ALARM) ? alm_m_d : clk_m_d;
    disp_s    = (mode_d >= acsd_pkg::MODE_ALARM) ? alm_s_d : clk_s_d;
    which     = 2'd0;
    is_tens   = 1'b0;
    fixed     = 1'b0;
    fixed_seg = acsd_pkg::SEG_BLANK;
    if (acsd_pkg::NumDigits >= 8) begin
      unique case (scan_q)
        3'd0:    begin which = 2'd0; is_tens = 1'b1; end
        3'd1:    begin which = 2'd0; is_tens = 1'b0; end
        3'd3:    begin which = 2'd1; is_tens = 1'b1; end
        3'd4:    begin which = 2'd1; is_tens = 1'b0; end
        3'd6:    begin which = 2'd2; is_tens = 1'b1; end
        3'd7:    begin which = 2'd2; is_tens = 1'b0; end
        default: begin fixed = 1'b1; fixed_seg = acsd_pkg::SEG_DASH; end
      endcase
    end else begin
      unique case (scan_q)
        3'd0:    begin which = 2'd0; is_tens = 1'b1; end
        3'd1:    begin which = 2'd0; is_tens = 1'b0; end
        3'd2:    begin which = 2'd1; is_tens = 1'b1; end
        3'd3:    begin which = 2'd1; is_tens = 1'b0; end
        3'd4:    begin which = 2'd2; is_tens = 1'b1; end
        3'd5:    begin which = 2'd2; is_tens = 1'b0; end
        default: begin fixed = 1'b1; fixed_seg = acsd_pkg::SEG_BLANK; end
      endcase
    end
    unique case (which)
      2'd0:    disp_val = disp_h;
      2'd1:    disp_val = disp_m;
      default: disp_val = disp_s;
    endcase
    if (fixed) begin
      segs = fixed_seg;
    end else if (blink_phase_d && (mode_d[1:0] == which + 2'd1)) begin
      segs = acsd_pkg::SEG_BLANK;
    end else if (is_tens) begin
      segs = acsd_pkg::seg_of(acsd_pkg::tens_of(disp_val));
    end else begin
      segs = acsd_pkg::seg_of(acsd_pkg::ones_of(disp_val));
    end
  end

  always_comb begin
    wtens                 = acsd_pkg::tens_of(wval);
    result_o.digit_select = scan_q;
    result_o.segments     = segs;
    result_o.alarm_led    = alarm_active_d && (flash_count_d < {1'b0, flash_half_q});
    result_o.write_valid  = wvalid;
    result_o.write_field  = wfield;
    result_o.write_bcd    = wvalid ? {wtens[2:0], acsd_pkg::ones_of(wval)} : 7'd0;
    result_o.current_mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_half_q     <= acsd_pkg::BlinkHalfReset;
      flash_half_q     <= acsd_pkg::FlashHalfReset;
      duration_q       <= acsd_pkg::DurationReset;
      mode_q           <= acsd_pkg::MODE_RUN;
      clk_h_q          <= 5'd23;
      clk_m_q          <= 6'd59;
      clk_s_q          <= 6'd50;
      alm_h_q          <= 5'd0;
      alm_m_q          <= 6'd0;
      alm_s_q          <= 6'd0;
      blink_phase_q    <= 1'b0;
      blink_count_q    <= 16'd0;
      scan_q           <= 3'd0;
      alarm_active_q   <= 1'b0;
      flash_count_q    <= 17'd0;
      duration_count_q <= 16'd0;
      match_before_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          acsd_pkg::REG_BLINK_HALF: blink_half_q <= cfg_wdata_i;
          acsd_pkg::REG_FLASH_HALF: flash_half_q <= cfg_wdata_i;
          acsd_pkg::REG_DURATION:   duration_q   <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
      if (advance_i) begin
        mode_q           <= mode_d;
        clk_h_q          <= clk_h_d;
        clk_m_q          <= clk_m_d;
        clk_s_q          <= clk_s_d;
        alm_h_q          <= alm_h_d;
        alm_m_q          <= alm_m_d;
        alm_s_q          <= alm_s_d;
        blink_phase_q    <= blink_phase_d;
        blink_count_q    <= blink_count_d;
        scan_q           <= scan_d;
        alarm_active_q   <= alarm_active_d;
        flash_count_q    <= flash_count_d;
        duration_count_q <= duration_count_d;
        match_before_q   <= match_before_d;
      end
    end
  end

endmodule

/* rtl/core/acsd_out_stage.sv */
// result register towards the output channel
module acsd_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                advance_o,
  input  acsd_pkg::result_t   result_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output acsd_pkg::result_t   result_o
);

  logic              valid_q;
  acsd_pkg::result_t result_q;

  assign advance_o = in_valid_i & (~valid_q | ~out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= advance_o | (valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* rtl/core/acsd_checker.sv */
// port-level checker for the alarm clock block and its bind
module acsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  segments_o,
  input logic        write_valid_o,
  input logic [1:0]  write_field_o,
  input logic [6:0]  write_bcd_o,
  input logic [2:0]  current_mode_o
);

  // stalled result transaction stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(segments_o)
      && $stable(current_mode_o))
  else $error("stalled result changed");

  // decimal point never lit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> segments_o[7])
  else $error("decimal point lit");

  // no write-back payload without write-back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_valid_o |-> write_field_o == acsd_pkg::WF_SECONDS
      && write_bcd_o == 7'd0)
  else $error("write-back payload without write-back");

  // write-back only from a clock set mode, matching field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_valid_o |->
      (current_mode_o == acsd_pkg::MODE_SET_CLK_H && write_field_o == acsd_pkg::WF_HOURS)
      || (current_mode_o == acsd_pkg::MODE_SET_CLK_M && write_field_o == acsd_pkg::WF_MINUTES)
      || (current_mode_o == acsd_pkg::MODE_SET_CLK_S && write_field_o == acsd_pkg::WF_SECONDS))
  else $error("write-back outside clock set mode");

endmodule

bind alarm_clock_set_and_display_top acsd_checker u_acsd_checker (.*);
